@@ src/dal_pkg.sv @@
// Shared types and codes for the door autolock controller.
package dal_pkg;

    typedef enum logic [1:0] {
        REQ_UPDATE = 2'd0,
        REQ_GRANT  = 2'd1,
        REQ_INIT   = 2'd2
    } req_kind_t;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_AUTO      = 3'd1,
        EV_TIMEOUT   = 3'd2,
        EV_UNLOCK    = 3'd3,
        EV_INIT_LOCK = 3'd4
    } event_code_t;

    localparam int unsigned LOCK_DELAY_RESET     = 32'd3000;
    localparam int unsigned UNLOCK_TIMEOUT_RESET = 32'd10000;

    // register indexes on the config port
    localparam logic REG_LOCK_DELAY     = 1'b0;
    localparam logic REG_UNLOCK_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        enable_request;
        logic        door_open;
        logic [31:0] now_ms;
    } in_word_t;

    typedef struct packed {
        logic        lock_engaged;
        logic [2:0]  event_code;
        logic        awaiting_open;
        logic        awaiting_relock;
    } out_word_t;

    typedef struct packed {
        logic [31:0] lock_delay_ms;
        logic [31:0] unlock_timeout_ms;
    } cfg_regs_t;

    typedef struct packed {
        logic locking_on;
        logic door_was_open;
        logic wait_open_flag;
        logic wait_relock_flag;
        logic lock_state;
    } ctrl_state_t;

endpackage

@@ src/dal_apb_regs.sv @@
// APB register file holding the lock delay and unlock timeout.
module dal_apb_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output dal_pkg::cfg_regs_t cfg
);

    logic [31:0] lock_delay_reg;
    logic [31:0] unlock_timeout_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lock_delay_reg     <= dal_pkg::LOCK_DELAY_RESET;
            unlock_timeout_reg <= dal_pkg::UNLOCK_TIMEOUT_RESET;
        end else if (wr_en) begin
            if (paddr[2] == dal_pkg::REG_LOCK_DELAY) begin
                lock_delay_reg <= pwdata;
            end else begin
                unlock_timeout_reg <= pwdata;
            end
        end
    end

    always_comb begin
        if (paddr[2] == dal_pkg::REG_LOCK_DELAY) begin
            prdata = lock_delay_reg;
        end else begin
            prdata = unlock_timeout_reg;
        end
    end

    assign cfg.lock_delay_ms     = lock_delay_reg;
    assign cfg.unlock_timeout_ms = unlock_timeout_reg;

endmodule

@@ src/dal_step.sv @@
// Next-state and result logic for one request word.
module dal_step #(
    parameter int TIME_BITS = 32
) (
    input  dal_pkg::in_word_t    in_word,
    input  dal_pkg::ctrl_state_t cur,
    input  logic [TIME_BITS-1:0] closed_stamp,
    input  logic [TIME_BITS-1:0] unlock_stamp,
    input  dal_pkg::cfg_regs_t   cfg,
    output dal_pkg::ctrl_state_t nxt,
    output logic [TIME_BITS-1:0] closed_stamp_next,
    output logic [TIME_BITS-1:0] unlock_stamp_next,
    output dal_pkg::out_word_t   result
);

    // compare width: wide enough for both the time base and the 32-bit registers
    localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

    logic [CW-1:0]        now_wide;
    logic [TIME_BITS-1:0] now_t;

    assign now_wide = CW'(in_word.now_ms);
    assign now_t    = now_wide[TIME_BITS-1:0];

    always_comb begin
        dal_pkg::ctrl_state_t st;
        dal_pkg::event_code_t ev;
        logic [TIME_BITS-1:0] cs;
        logic [TIME_BITS-1:0] us;
        logic [TIME_BITS-1:0] diff_closed;
        logic [TIME_BITS-1:0] diff_unlock;
        logic                 en;
        logic                 door;

        st          = cur;
        ev          = dal_pkg::EV_NONE;
        cs          = closed_stamp;
        us          = unlock_stamp;
        en          = in_word.enable_request;
        door        = in_word.door_open;
        diff_closed = '0;
        diff_unlock = '0;

        unique case (in_word.req_type)
            dal_pkg::REQ_UPDATE: begin
                // enable edges
                if (!st.locking_on && en) begin
                    st.locking_on = 1'b1;
                    if (!door) begin
                        cs                  = now_t;
                        st.wait_relock_flag = 1'b1;
                    end
                end else if (st.locking_on && !en) begin
                    st.locking_on       = 1'b0;
                    st.wait_open_flag   = 1'b0;
                    st.wait_relock_flag = 1'b0;
                    st.lock_state       = 1'b0;
                    ev                  = dal_pkg::EV_UNLOCK;
                end
                // door edges
                if (door && !st.door_was_open) begin
                    st.wait_open_flag   = 1'b0;
                    st.wait_relock_flag = 1'b0;
                end
                if (!door && st.door_was_open) begin
                    cs = now_t;
                    if (en && !st.lock_state) begin
                        st.wait_relock_flag = 1'b1;
                    end
                end
                st.door_was_open = door;

                diff_closed = now_t - cs;
                diff_unlock = now_t - us;

                if (en) begin
                    if (st.wait_relock_flag && !door && !st.lock_state &&
                        CW'(diff_closed) >= CW'(cfg.lock_delay_ms)) begin
                        st.lock_state       = 1'b1;
                        st.wait_open_flag   = 1'b0;
                        st.wait_relock_flag = 1'b0;
                        ev                  = dal_pkg::EV_AUTO;
                    end else if (st.wait_open_flag && !door && !st.lock_state &&
                                 CW'(diff_unlock) >= CW'(cfg.unlock_timeout_ms)) begin
                        st.lock_state       = 1'b1;
                        st.wait_open_flag   = 1'b0;
                        st.wait_relock_flag = 1'b0;
                        ev                  = dal_pkg::EV_TIMEOUT;
                    end
                end
            end
            dal_pkg::REQ_GRANT: begin
                st.lock_state       = 1'b0;
                ev                  = dal_pkg::EV_UNLOCK;
                us                  = now_t;
                st.wait_open_flag   = !door;
                st.wait_relock_flag = 1'b0;
            end
            dal_pkg::REQ_INIT: begin
                st.door_was_open    = door;
                st.locking_on       = en;
                st.wait_open_flag   = 1'b0;
                st.wait_relock_flag = 1'b0;
                if (!en || door) begin
                    st.lock_state = 1'b0;
                    ev            = dal_pkg::EV_UNLOCK;
                end else begin
                    st.lock_state = 1'b1;
                    ev            = dal_pkg::EV_INIT_LOCK;
                end
            end
            default: begin
                // unused request kind: state holds, no event
            end
        endcase

        nxt                    = st;
        closed_stamp_next      = cs;
        unlock_stamp_next      = us;
        result.lock_engaged    = st.lock_state;
        result.event_code      = ev;
        result.awaiting_open   = st.wait_open_flag;
        result.awaiting_relock = st.wait_relock_flag;
    end

endmodule

@@ src/door_autolock_controller_core.sv @@
// Top level of the door autolock controller: channels, state and pipeline registers.
//
// Usage
//   s_ channel: one request word per handshake (req_type, enable_request,
//     door_open, now_ms). req_type 0 = periodic update, 1 = grant access,
//     2 = initialize; 3 is ignored and just reports the current state.
//   m_ channel: exactly one result word per request word, in order
//     (lock_engaged, event_code, awaiting_open, awaiting_relock).
//   APB port: lock_delay_ms at 0x0, unlock_timeout_ms at 0x4. Write only
//     while no request is in flight.
// Timing
//   One word per cycle sustained while m_ready is high: a single pass of
//   compares and flag logic. A word is held in the input register; the state
//   updates as it moves on to the output register, which holds its result.
// Reset (aresetn low, synchronous)
//   Lock released, all flags clear, both pipeline stages empty, delay
//   registers back to 3000 and 10000 ms. Timestamps are not reset.
// Stall
//   With m_ready low the output register holds; the input register still
//   takes one more word, then s_ready drops until the output drains.
module door_autolock_controller_core #(
    parameter int TIME_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    // request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  dal_pkg::in_word_t  s_data,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output dal_pkg::out_word_t m_data,
    // config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    dal_pkg::cfg_regs_t   cfg;

    // input stage
    dal_pkg::in_word_t    in_word_reg;
    logic                 in_valid_reg;
    logic                 in_valid_next;

    // output stage
    dal_pkg::out_word_t   out_word_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    // controller state
    dal_pkg::ctrl_state_t state_reg;
    dal_pkg::ctrl_state_t state_next;
    logic [TIME_BITS-1:0] closed_stamp_reg;
    logic [TIME_BITS-1:0] closed_stamp_next;
    logic [TIME_BITS-1:0] unlock_stamp_reg;
    logic [TIME_BITS-1:0] unlock_stamp_next;

    dal_pkg::out_word_t   step_result;

    logic                 advance;   // output stage can take a word this cycle
    logic                 commit;    // a word moves from input to output stage
    logic                 s_take;

    dal_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dal_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .in_word           (in_word_reg),
        .cur               (state_reg),
        .closed_stamp      (closed_stamp_reg),
        .unlock_stamp      (unlock_stamp_reg),
        .cfg               (cfg),
        .nxt               (state_next),
        .closed_stamp_next (closed_stamp_next),
        .unlock_stamp_next (unlock_stamp_next),
        .result            (step_result)
    );

    assign advance = !out_valid_reg || m_ready;
    assign commit  = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = in_valid_reg;
        end
    end

    // control: pipeline valids and controller flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (commit) begin
                state_reg <= state_next;
            end
        end
    end

    // payload: no reset needed
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_word_reg <= s_data;
        end
        if (commit) begin
            out_word_reg     <= step_result;
            closed_stamp_reg <= closed_stamp_next;
            unlock_stamp_reg <= unlock_stamp_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

    // a locked door never has a pending wait
    a_locked_no_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.lock_engaged |-> !m_data.awaiting_open && !m_data.awaiting_relock)
        else $error("locked result with a wait flag set");

    // an unlock report always shows the lock open
    a_unlock_open: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.event_code == dal_pkg::EV_UNLOCK) |-> !m_data.lock_engaged)
        else $error("unlock event with lock engaged");

    // lock events always show the lock closed
    a_lock_event_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.event_code == dal_pkg::EV_AUTO ||
                    m_data.event_code == dal_pkg::EV_TIMEOUT ||
                    m_data.event_code == dal_pkg::EV_INIT_LOCK) |-> m_data.lock_engaged)
        else $error("lock event with lock released");

    // a committed word shows up at the output next cycle
    a_commit_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_valid)
        else $error("committed word lost");

    // backpressure only when both stages are full and the sink stalls
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("s_ready low without a full pipeline");

endmodule
